// ===== rtl/spp_pkg.sv =====
// Shared types, codes and constants of the half-step positioner.
`default_nettype none
package spp_pkg;

    localparam int PositionBits = 16;
    localparam int QueueDepth   = 2;
    localparam int DivBits      = 16;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_ABS   = 3'd1;
    localparam logic [2:0] CMD_REL   = 3'd2;
    localparam logic [2:0] CMD_TIMED = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MOVING = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_BUSY   = 2'd3;

    localparam logic [1:0] REG_MIN_POS   = 2'd0;
    localparam logic [1:0] REG_MAX_POS   = 2'd1;
    localparam logic [1:0] REG_DWELL     = 2'd2;
    localparam logic [1:0] REG_STEP_DLY  = 2'd3;

    localparam logic [15:0] MinPosReset    = 16'd0;
    localparam logic [15:0] MaxPosReset    = 16'hFFFF;
    localparam logic [15:0] DwellReset     = 16'd1000;
    localparam logic [3:0]  StepDelayReset = 4'd1;

    typedef enum logic [2:0] {
        K_TICK,
        K_ABS,
        K_REL,
        K_LOAD,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] target;
        logic [15:0] steps;
        logic        inward;
    } t_item;

    typedef struct packed {
        logic [15:0] min_pos;
        logic [15:0] max_pos;
        logic [15:0] dwell;
        logic [3:0]  step_delay;
    } t_cfg;

    function automatic logic [3:0] half_step(input logic [2:0] ph);
        logic [3:0] c;
        unique case (ph)
            3'd0:    c = 4'd8;
            3'd1:    c = 4'd12;
            3'd2:    c = 4'd4;
            3'd3:    c = 4'd6;
            3'd4:    c = 4'd2;
            3'd5:    c = 4'd3;
            3'd6:    c = 4'd1;
            default: c = 4'd9;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/spp_queue.sv =====
// Small FIFO of classified commands between front and back.
`default_nettype none
module spp_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  spp_pkg::t_item      i_item,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output spp_pkg::t_item      o_item
);
    import spp_pkg::*;

    localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntBits = $clog2(QueueDepth + 1);

    t_item               r_mem [QueueDepth];
    logic [PtrBits-1:0]  r_wr_ptr;
    logic [PtrBits-1:0]  r_rd_ptr;
    logic [CntBits-1:0]  r_count;

    assign o_full  = (r_count == CntBits'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrBits'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrBits'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spp_front.sv =====
// Command intake: classify beats and convert timed moves to step counts.
`default_nettype none
module spp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [2:0]          i_cmd,
    input  wire  [15:0]         i_target,
    input  wire  [15:0]         i_amount,
    input  wire                 i_inward,
    input  wire  [15:0]         i_duration,
    input  wire  [3:0]          i_step_delay,
    input  wire                 i_q_full,
    output logic                o_push,
    output spp_pkg::t_item      o_item
);
    import spp_pkg::*;

    localparam int CntBits = $clog2(DivBits);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state              r_state;
    logic [DivBits-1:0]  r_quo;
    logic [3:0]          r_rem;
    logic [3:0]          r_div;
    logic [CntBits-1:0]  r_cnt;
    logic [15:0]         r_target;
    logic                r_inward;

    logic                accept;
    logic                div_last;
    logic [4:0]          rem_sh;
    logic                ge;
    logic [3:0]          n_rem;
    logic [DivBits-1:0]  n_quo;
    t_kind               kind;

    assign o_ready  = (r_state == S_IDLE) && !i_q_full;
    assign accept   = i_valid && o_ready;
    assign div_last = (r_state == S_DIV) && (r_cnt == CntBits'(DivBits - 1));

    assign rem_sh = {r_rem, r_quo[DivBits-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});
    assign n_rem  = ge ? 4'(rem_sh - {1'b0, r_div}) : rem_sh[3:0];
    assign n_quo  = {r_quo[DivBits-2:0], ge};

    always_comb begin
        unique case (i_cmd)
            CMD_TICK:         kind = K_TICK;
            CMD_ABS:          kind = K_ABS;
            CMD_REL:          kind = K_REL;
            CMD_LOAD:         kind = K_LOAD;
            default:          kind = K_NOP;
        endcase
    end

    always_comb begin
        o_push = (accept && (i_cmd != CMD_TIMED)) || div_last;
        if (r_state == S_DIV) begin
            o_item.kind   = K_REL;
            o_item.target = r_target;
            o_item.steps  = n_quo;
            o_item.inward = r_inward;
        end else begin
            o_item.kind   = kind;
            o_item.target = i_target;
            o_item.steps  = i_amount;
            o_item.inward = i_inward;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd == CMD_TIMED)) begin
                        r_state  <= S_DIV;
                        r_cnt    <= '0;
                        r_quo    <= i_duration;
                        r_rem    <= '0;
                        r_div    <= (i_step_delay == '0) ? 4'd1 : i_step_delay;
                        r_target <= i_target;
                        r_inward <= i_inward;
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (div_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spp_exec.sv =====
// Move engine: position tracking, half-step sequencing and result register.
`default_nettype none
module spp_exec #(
    parameter int P = spp_pkg::PositionBits
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  spp_pkg::t_cfg       i_cfg,
    input  wire                 i_q_valid,
    input  spp_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [23:0]         o_data
);
    import spp_pkg::*;

    localparam int W = ((P > 16) ? P : 16) + 2;

    logic [P-1:0]  r_cur, n_cur;
    logic [P-1:0]  r_goal, n_goal;
    logic [2:0]    r_phase, n_phase;
    logic [15:0]   r_dwell, n_dwell;
    logic          r_busy, n_busy;
    logic          r_going_in, n_going_in;
    logic          r_out_valid;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_pos, n_pos;
    logic [3:0]    r_coils, n_coils;
    logic          r_moving, n_moving;
    logic          r_done, n_done;

    logic [W-1:0]  cur_w;
    logic [W-1:0]  abs_w;
    logic [W-1:0]  cand;
    logic          bad;
    logic [15:0]   dw;
    logic [16:0]   dwell_inc;
    logic [P-1:0]  cur_step;

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = {r_done, r_moving, r_coils, r_pos, r_status};

    assign cur_w = W'(r_cur);
    assign abs_w = W'(i_item.target);

    always_comb begin
        if (i_item.kind == K_ABS) begin
            cand = abs_w;
        end else if (i_item.inward) begin
            cand = cur_w - W'(i_item.steps);
        end else begin
            cand = cur_w + W'(i_item.steps);
        end
    end

    assign bad = cand[W-1] || (|cand[W-2:P]) ||
                 (cand < W'(i_cfg.min_pos)) || (cand > W'(i_cfg.max_pos));

    assign dw        = (i_cfg.dwell == '0) ? 16'd1 : i_cfg.dwell;
    assign dwell_inc = 17'(r_dwell) + 17'd1;
    assign cur_step  = r_going_in ? r_cur - 1'b1 : r_cur + 1'b1;

    always_comb begin
        n_cur      = r_cur;
        n_goal     = r_goal;
        n_phase    = r_phase;
        n_dwell    = r_dwell;
        n_busy     = r_busy;
        n_going_in = r_going_in;
        n_status   = ST_OK;
        n_coils    = '0;
        n_done     = 1'b0;
        case (i_item.kind)
            K_ABS, K_REL: begin
                if (r_busy) begin
                    n_status = ST_BUSY;
                end else if (bad) begin
                    n_status = ST_RANGE;
                end else if (cand[P-1:0] == r_cur) begin
                    n_done = 1'b1;
                end else begin
                    n_goal     = cand[P-1:0];
                    n_going_in = (cand[P-1:0] < r_cur);
                    n_phase    = '0;
                    n_dwell    = '0;
                    n_busy     = 1'b1;
                    n_status   = ST_MOVING;
                end
            end
            K_LOAD: begin
                if (r_busy) begin
                    n_status = ST_BUSY;
                end else begin
                    n_cur = abs_w[P-1:0];
                end
            end
            K_TICK: begin
                if (r_busy) begin
                    n_coils  = half_step(r_going_in ? r_phase : ~r_phase);
                    n_status = ST_MOVING;
                    n_dwell  = dwell_inc[15:0];
                    if (dwell_inc >= 17'(dw)) begin
                        n_dwell = '0;
                        if (r_phase == 3'd7) begin
                            n_phase = '0;
                            n_cur   = cur_step;
                            if (cur_step == r_goal) begin
                                n_busy   = 1'b0;
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end
                        end else begin
                            n_phase = r_phase + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_status = r_busy ? ST_MOVING : ST_OK;
            end
        endcase
        n_pos    = W'(n_cur) >> 0 == '0 ? 16'd0 : 16'(W'(n_cur));
        n_moving = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_goal      <= '0;
            r_phase     <= '0;
            r_dwell     <= '0;
            r_busy      <= 1'b0;
            r_going_in  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur      <= n_cur;
                r_goal     <= n_goal;
                r_phase    <= n_phase;
                r_dwell    <= n_dwell;
                r_busy     <= n_busy;
                r_going_in <= n_going_in;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_coils  <= n_coils;
            r_moving <= n_moving;
            r_done   <= n_done;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/stepper_half_step_positioner.sv =====
// Top level of the half-step stepper positioner.
// Input beats on the s_axis channel carry one command each: tuser holds cmd
// (tick, move absolute, move relative, move timed, load position) and tdata
// the target, amount, direction and duration. Every input beat yields exactly
// one result beat on the m_axis channel with status, position, coil drive,
// moving and done flags, in command order.
// The front end accepts a beat and queues it; a timed move first runs a
// restoring divide of duration by the step delay, one quotient bit a cycle,
// and holds s_axis_tready low until the divide is done. The back end retires
// one queued command per cycle into the output register while the receiver
// takes results, so each result passes the queue and then the output register.
// Sustained rate: one beat per cycle for non-timed commands while the
// receiver keeps up; a timed move holds off the next beat until its divide ends.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, and s_axis_tready drops; nothing is lost.
// A synchronous reset clears position, move state and queue, and loads the
// defaults min 0, max 65535, dwell 1000 ticks, step delay 1 ms. Registers are
// written through i_cfg_*; the user must do so only while idle, unenforced.
`default_nettype none
module stepper_half_step_positioner #(
    parameter int POSITION_BITS = spp_pkg::PositionBits
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // target[15:0], amount[31:16], inward[32], duration[48:33], zero[55:49]
    input  wire  [55:0] s_axis_tdata,
    // cmd[2:0]
    input  wire  [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[1:0], position[17:2], coils[21:18], moving[22], done_res[23]
    output logic [23:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);
    import spp_pkg::*;

    t_cfg   r_cfg;
    t_item  push_item;
    t_item  q_item;
    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pos    <= MinPosReset;
            r_cfg.max_pos    <= MaxPosReset;
            r_cfg.dwell      <= DwellReset;
            r_cfg.step_delay <= StepDelayReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_POS:  r_cfg.min_pos    <= i_cfg_data;
                REG_MAX_POS:  r_cfg.max_pos    <= i_cfg_data;
                REG_DWELL:    r_cfg.dwell      <= i_cfg_data;
                REG_STEP_DLY: r_cfg.step_delay <= i_cfg_data[3:0];
                default:      r_cfg.dwell      <= r_cfg.dwell;
            endcase
        end
    end

    spp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_target     (s_axis_tdata[15:0]),
        .i_amount     (s_axis_tdata[31:16]),
        .i_inward     (s_axis_tdata[32]),
        .i_duration   (s_axis_tdata[48:33]),
        .i_step_delay (r_cfg.step_delay),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    spp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    spp_exec #(
        .P (POSITION_BITS)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule
`default_nettype wire
